// File: hdl/bgdc_pkg.sv
// Shared types, constants and helper functions for the button gesture digit counter.
// No dependencies; every other file in hdl/ except bgdc_if imports this package.
package bgdc_pkg;

  localparam int unsigned TimerBits = 16;
  localparam int unsigned CfgBits   = 16;
  localparam int unsigned CmpBits   = (TimerBits > CfgBits) ? TimerBits : CfgBits;
  localparam int unsigned AddrBits  = 4;
  localparam int unsigned DataBits  = 32;

  typedef logic [TimerBits-1:0] timer_t;
  typedef logic [CfgBits-1:0]   cfg_word_t;
  typedef logic [CmpBits-1:0]   cmp_t;
  typedef logic [3:0]           digit_t;
  typedef logic [6:0]           seg_t;
  typedef logic [1:0]           reg_idx_t;

  localparam timer_t TimerMax = '1;
  localparam digit_t DigitMax = 4'd9;

  typedef enum logic [2:0] {
    GestNone       = 3'd0,
    GestPress      = 3'd1,
    GestClick      = 3'd2,
    GestLongStart  = 3'd3,
    GestLongRepeat = 3'd4,
    GestLongEnd    = 3'd5
  } gesture_e;

  localparam reg_idx_t RegDebounce    = 2'd0;
  localparam reg_idx_t RegClickWindow = 2'd1;
  localparam reg_idx_t RegLongPress   = 2'd2;
  localparam reg_idx_t RegRepeat      = 2'd3;

  localparam cfg_word_t DebounceReset    = 16'd50;
  localparam cfg_word_t ClickWindowReset = 16'd400;
  localparam cfg_word_t LongPressReset   = 16'd1000;
  localparam cfg_word_t RepeatReset      = 16'd500;

  typedef struct packed {
    cfg_word_t debounce_ticks;
    cfg_word_t click_window_ticks;
    cfg_word_t long_press_ticks;
    cfg_word_t repeat_ticks;
  } cfg_t;

  function automatic seg_t seg_of(digit_t d);
    seg_t s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h3F;
    endcase
    return s;
  endfunction

  function automatic timer_t sat_inc(timer_t t);
    return (t == TimerMax) ? t : t + timer_t'(1);
  endfunction

  function automatic digit_t digit_step(digit_t d);
    return (d >= DigitMax) ? 4'd0 : d + 4'd1;
  endfunction

endpackage

// File: hdl/bgdc_if.sv
// Valid/ready channel interfaces for the button gesture digit counter.
// Depends on nothing; widths follow the item and result fields.
interface bgdc_item_if;
  logic valid;
  logic ready;
  logic operation;
  logic level_pressed;

  modport source (output valid, output operation, output level_pressed, input ready);
  modport sink   (input valid, input operation, input level_pressed, output ready);
endinterface

interface bgdc_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] gesture;
  logic [3:0] digit;
  logic [6:0] segments;

  modport source (output valid, output gesture, output digit, output segments, input ready);
  modport sink   (input valid, input gesture, input digit, input segments, output ready);
endinterface

// File: hdl/bgdc_cfg.sv
// APB-style register file holding the four timing thresholds.
// Depends on bgdc_pkg.
module bgdc_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bgdc_pkg::AddrBits-1:0] paddr,
  input  logic [bgdc_pkg::DataBits-1:0] pwdata,
  output logic [bgdc_pkg::DataBits-1:0] prdata,
  output logic                        pready,
  output bgdc_pkg::cfg_t              cfg_o
);
  import bgdc_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_t idx;
  logic     wr_en;
  cfg_word_t rd_word;

  assign idx    = paddr[AddrBits-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegDebounce:    cfg_d.debounce_ticks     = pwdata[CfgBits-1:0];
        RegClickWindow: cfg_d.click_window_ticks = pwdata[CfgBits-1:0];
        RegLongPress:   cfg_d.long_press_ticks   = pwdata[CfgBits-1:0];
        RegRepeat:      cfg_d.repeat_ticks       = pwdata[CfgBits-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegDebounce:    rd_word = cfg_q.debounce_ticks;
      RegClickWindow: rd_word = cfg_q.click_window_ticks;
      RegLongPress:   rd_word = cfg_q.long_press_ticks;
      RegRepeat:      rd_word = cfg_q.repeat_ticks;
      default:        rd_word = '0;
    endcase
  end

  assign prdata = DataBits'(rd_word);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks     <= DebounceReset;
      cfg_q.click_window_ticks <= ClickWindowReset;
      cfg_q.long_press_ticks   <= LongPressReset;
      cfg_q.repeat_ticks       <= RepeatReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: hdl/bgdc_gesture.sv
// Gesture state: debounce, hold and click timers, flags and the wrapping digit.
// Depends on bgdc_pkg. Computes one item's gesture and digit; state moves on step_i.
module bgdc_gesture (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bgdc_pkg::cfg_t     cfg_i,
  input  logic               step_i,
  input  logic               is_edge_i,
  input  logic               level_i,
  output bgdc_pkg::gesture_e gesture_o,
  output bgdc_pkg::digit_t   digit_o
);
  import bgdc_pkg::*;

  logic   held_q, held_d;
  logic   long_q, long_d;
  logic   pend_q, pend_d;
  logic   seen_q, seen_d;
  timer_t since_edge_q, since_edge_d;
  timer_t since_rel_q, since_rel_d;
  timer_t hold_q, hold_d;
  digit_t count_q, count_d;

  timer_t    hold_inc, rel_inc;
  cfg_word_t limit;
  logic      bounce;

  assign hold_inc = sat_inc(hold_q);
  assign rel_inc  = sat_inc(since_rel_q);
  assign limit    = long_q ? cfg_i.repeat_ticks : cfg_i.long_press_ticks;
  assign bounce   = seen_q && (cmp_t'(since_edge_q) < cmp_t'(cfg_i.debounce_ticks));

  always_comb begin
    held_d       = held_q;
    long_d       = long_q;
    pend_d       = pend_q;
    seen_d       = seen_q;
    since_edge_d = since_edge_q;
    since_rel_d  = since_rel_q;
    hold_d       = hold_q;
    count_d      = count_q;
    gesture_o    = GestNone;
    if (!is_edge_i) begin
      since_edge_d = sat_inc(since_edge_q);
      // a held button owns the tick; the click window runs only when released
      if (held_q) begin
        if (cmp_t'(hold_inc) >= cmp_t'(limit)) begin
          hold_d    = '0;
          gesture_o = long_q ? GestLongRepeat : GestLongStart;
          long_d    = 1'b1;
          count_d   = digit_step(count_q);
        end else begin
          hold_d = hold_inc;
        end
      end else if (pend_q) begin
        since_rel_d = rel_inc;
        if (cmp_t'(rel_inc) >= cmp_t'(cfg_i.click_window_ticks)) begin
          pend_d    = 1'b0;
          gesture_o = GestClick;
          count_d   = digit_step(count_q);
        end
      end
    end else begin
      // every edge restarts the hold timer, even one dropped as bounce
      hold_d = '0;
      if (!bounce) begin
        seen_d       = 1'b1;
        since_edge_d = '0;
        if (level_i) begin
          pend_d    = 1'b0;
          held_d    = 1'b1;
          long_d    = 1'b0;
          gesture_o = GestPress;
        end else begin
          held_d = 1'b0;
          if (long_q) begin
            long_d    = 1'b0;
            gesture_o = GestLongEnd;
          end else begin
            pend_d      = 1'b1;
            since_rel_d = '0;
          end
        end
      end
    end
  end

  assign digit_o = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q       <= 1'b0;
      long_q       <= 1'b0;
      pend_q       <= 1'b0;
      seen_q       <= 1'b0;
      since_edge_q <= '0;
      since_rel_q  <= '0;
      hold_q       <= '0;
      count_q      <= '0;
    end else if (step_i) begin
      held_q       <= held_d;
      long_q       <= long_d;
      pend_q       <= pend_d;
      seen_q       <= seen_d;
      since_edge_q <= since_edge_d;
      since_rel_q  <= since_rel_d;
      hold_q       <= hold_d;
      count_q      <= count_d;
    end
  end

endmodule

// File: hdl/button_gesture_digit_counter.sv
// Channel    | Dir | Payload                           | Handshake
// item_i     | in  | operation, level_pressed          | valid/ready
// result_o   | out | gesture, digit, segments          | valid/ready
// APB        | in  | debounce/click/long/repeat ticks  | psel/penable, pready tied high
//
// One item enters per cycle while item_i.ready is high; its result reaches result_o
// through the input register, then the gesture logic into the result register.
// Reset clears all flags, timers and the digit and loads the default thresholds.
// A stalled result holds in the result register while the input register still
// takes one more item; ready then falls until the result is taken.
// Top level of the button gesture digit counter; depends on bgdc_pkg, bgdc_if,
// bgdc_cfg and bgdc_gesture.
module button_gesture_digit_counter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bgdc_item_if.sink                     item_i,
  bgdc_result_if.source                 result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bgdc_pkg::AddrBits-1:0] paddr,
  input  logic [bgdc_pkg::DataBits-1:0] pwdata,
  output logic [bgdc_pkg::DataBits-1:0] prdata,
  output logic                          pready
);
  import bgdc_pkg::*;

  cfg_t     cfg;
  gesture_e gest;
  digit_t   digit;

  logic     in_valid_q, in_valid_d;
  logic     in_op_q, in_lvl_q;
  logic     out_valid_q, out_valid_d;
  gesture_e out_gest_q;
  digit_t   out_digit_q;
  seg_t     out_seg_q;
  logic     advance, take;

  bgdc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bgdc_gesture u_gesture (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .step_i    (advance),
    .is_edge_i (in_op_q),
    .level_i   (in_lvl_q),
    .gesture_o (gest),
    .digit_o   (digit)
  );

  // move the held item into the result register when that slot frees up
  assign advance      = in_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !in_valid_q || advance;
  assign take         = item_i.valid && item_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_op_q  <= item_i.operation;
      in_lvl_q <= item_i.level_pressed;
    end
    if (advance) begin
      out_gest_q  <= gest;
      out_digit_q <= digit;
      out_seg_q   <= seg_of(digit);
    end
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.gesture  = out_gest_q;
  assign result_o.digit    = out_digit_q;
  assign result_o.segments = out_seg_q;

endmodule

// File: hdl/bgdc_checker.sv
// Port-level checks on the result channel of the button gesture digit counter.
// Depends on bgdc_pkg; bound to the top level at the end of this file.
module bgdc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] gesture,
  input logic [3:0] digit,
  input logic [6:0] segments
);
  import bgdc_pkg::*;

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (digit <= DigitMax))
    else $error("digit out of range");

  a_seg_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (segments == seg_of(digit)))
    else $error("segments do not match digit");

  a_gesture_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (gesture == GestNone || gesture == GestPress || gesture == GestClick ||
                   gesture == GestLongStart || gesture == GestLongRepeat ||
                   gesture == GestLongEnd))
    else $error("gesture code out of range");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(gesture) && $stable(digit)))
    else $error("stalled result changed");

endmodule

bind button_gesture_digit_counter bgdc_checker u_bgdc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (result_o.valid),
  .out_ready (result_o.ready),
  .gesture   (result_o.gesture),
  .digit     (result_o.digit),
  .segments  (result_o.segments)
);
